@@ rtl/rrwc_pkg.sv @@
`default_nettype none

package rrwc_pkg;

    localparam int unsigned MUL_W     = 16;
    localparam int unsigned MUL_CNT_W = $clog2(MUL_W) + 1;
    localparam int unsigned DIV_NUM_W = 35;
    localparam int unsigned DIV_DEN_W = 17;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_NUM_W) + 1;

    localparam logic [16:0] MAX_TASKS      = 17'd1024;
    localparam logic [16:0] MIN_CAP_Q8     = 17'd5120;
    localparam logic [16:0] HALF_MIN_CAP   = 17'd2560;
    localparam logic [16:0] MIN_SRV_CAP_Q8 = 17'd25600;
    localparam logic [16:0] MAX_CAP_Q8     = 17'd76800;
    localparam logic [16:0] HALF_MAX_CAP   = 17'd38400;
    localparam logic [16:0] WINDOW_RESET   = 17'd5120;
    localparam logic [16:0] THRESH_RESET   = 17'd32768;
    localparam logic [16:0] GROW_STEP_Q8   = 17'd256;

    localparam logic [12:0] RTO_SERVER_DEF = 13'd1500;
    localparam logic [12:0] RTO_CLIENT_DEF = 13'd2500;
    localparam logic [19:0] RTO_VAR_FLOOR  = 20'd250;
    localparam logic [19:0] RTO_SOFT_CAP   = 20'd5000;
    localparam logic [19:0] RTO_HARD_CAP   = 20'd6000;
    localparam logic [19:0] RTO_FAST_RTT   = 20'd2500;
    localparam logic [19:0] RTO_UDP_HIGH   = 20'd1500;
    localparam logic [19:0] RTO_UDP_LOW    = 20'd500;
    localparam logic [19:0] RTO_TCP_LOW    = 20'd4000;
    localparam logic [15:0] UDP_RTT_KNEE   = 16'd150;
    localparam logic [15:0] VAR_MIN        = 16'd100;
    localparam logic [15:0] SLOW_SAMPLE_MS = 16'd2500;

    localparam logic [16:0] SHRINK_DIVISOR = 17'd5;
    localparam logic [16:0] FLOOR_DIVISOR  = 17'd125;

    localparam logic CFG_SERVER_MODE = 1'b0;
    localparam logic CFG_UDP_LINK    = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic        sample_valid;
        logic [15:0] sample_ms;
        logic        duplicate;
        logic        dupe_rate_active;
        logic [9:0]  count_before;
        logic [9:0]  count_after;
        logic [15:0] recv_per_sec;
        logic        coin;
    } in_t;

    typedef struct packed {
        logic [12:0] timeout_ms;
        logic [16:0] window_q8;
    } out_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] steps;
    } div_req_t;

endpackage

`default_nettype wire

@@ rtl/rtt_rto_window_controller.sv @@
// RTT estimator, retransmission timeout and task window controller.
//
// Each request on the input channel reports one task outcome. The block
// updates its round-trip estimates and the task window, and returns one
// result request carrying the retransmission timeout in milliseconds and
// the window in unsigned Q9.8.
//
// The configuration channel is always ready and selects server mode and
// UDP links; it should be written only while no request is in flight.
//
// One request is processed at a time. A failure with no task cleared goes
// straight to the result; otherwise it applies the 0.125 shrink step, or the
// 0.075 step, which needs a serial divide. A success can use a bit-serial 16x16
// multiply, a radix-2 divide for the congestion avoidance step and one for the
// window floor; all three divides share one serial divider. The next request is
// accepted the cycle after the result is loaded into the output register, so a
// stalled receiver holds one result there and a further result waits inside.
// Reset restores a window of 20.0, a threshold of 128.0 and no RTT estimate.
`default_nettype none

module rtt_rto_window_controller (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire rrwc_pkg::in_t  in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output rrwc_pkg::out_t      out_data,
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic           cfg_index,
    input  wire logic           cfg_data
);
    import rrwc_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RTT_UPD,
        ST_SLOW_UPD,
        ST_DUP_UPD,
        ST_DECIDE,
        ST_SHRINK_DEC,
        ST_SHRINK_DIV,
        ST_SHRINK_APPLY,
        ST_MUL_WAIT,
        ST_GROW_CHECK,
        ST_GROW_DIV,
        ST_GROW_FLOOR,
        ST_FLOOR_DIV,
        ST_GROW_CAP,
        ST_TO_BASE,
        ST_TO_FINAL
    } state_t;

    state_t         state_reg;
    in_t            item_reg;
    out_t           out_data_reg;
    logic           out_valid_reg;
    logic           server_mode_reg;
    logic           udp_link_reg;
    logic           srtt_valid_reg;
    logic [15:0]    srtt_reg;
    logic [15:0]    var_reg;
    logic           slow_valid_reg;
    logic [15:0]    slow_reg;
    logic [16:0]    window_reg;
    logic [16:0]    thresh_reg;
    logic [16:0]    dec_reg;
    logic [31:0]    prod_reg;
    logic [17:0]    wgrow_reg;
    logic [18:0]    rto_base_reg;

    logic                   mul_start;
    logic                   mul_done;
    logic [2*MUL_W-1:0]     mul_product;
    div_req_t               div_req;
    logic [DIV_NUM_W-1:0]   div_dividend;
    logic [DIV_DEN_W-1:0]   div_divisor;
    logic                   div_done;
    logic [DIV_NUM_W-1:0]   div_quotient;

    logic [15:0]    t_half;
    logic [15:0]    diff;
    logic [17:0]    var_sum;
    logic [18:0]    srtt_sum;
    logic [15:0]    srtt_first_var_next;
    logic [15:0]    srtt_upd_next;
    logic [15:0]    var_upd_next;
    logic [18:0]    slow_sum;
    logic [16:0]    dup_m;
    logic [16:0]    dup_m_cap;
    logic           rtt_gt_slow;
    logic           slow_sample;
    logic [10:0]    after_plus1;
    logic           shrink_cond;
    logic [9:0]     before_c;
    logic [9:0]     after_c;
    logic [9:0]     d;
    logic [16:0]    d96;
    logic [17:0]    w_signed;
    logic           w_neg;
    logic [16:0]    window_shrink_next;
    logic [16:0]    cap;
    logic [36:0]    prod_x32;
    logic [34:0]    prod_x8;
    logic [23:0]    w125;
    logic [24:0]    wg125;
    logic [18:0]    slow_x5;
    logic           grow_cond;
    logic           grow_by_step;
    logic           floor_cond;
    logic [17:0]    three_r;
    logic [17:0]    v4;
    logic [17:0]    vterm;
    logic [18:0]    rto_base_next;
    logic [19:0]    rto1;
    logic [19:0]    rto2;
    logic [19:0]    lo;
    logic [19:0]    rto3;
    logic [19:0]    rto4;
    logic [12:0]    timeout_next;
    logic           out_free;

    always_comb
    begin
        t_half              = {1'b0, item_reg.sample_ms[15:1]};
        srtt_first_var_next = (t_half > VAR_MIN) ? t_half : VAR_MIN;
        diff                = (srtt_reg > item_reg.sample_ms) ? (srtt_reg - item_reg.sample_ms)
                                                              : (item_reg.sample_ms - srtt_reg);
        var_sum             = {2'b00, var_reg} + {1'b0, var_reg, 1'b0} + {2'b00, diff};
        srtt_sum            = {srtt_reg, 3'b000} - {3'b000, srtt_reg}
                              + {3'b000, item_reg.sample_ms};
        srtt_upd_next       = srtt_sum[18:3];
        var_upd_next        = var_sum[17:2];
        slow_sum            = {slow_reg, 3'b000} - {3'b000, slow_reg} + {3'b000, srtt_reg};

        dup_m               = {1'b0, var_reg} + {3'b000, srtt_reg[15:2]};
        dup_m_cap           = (dup_m > {1'b0, srtt_reg}) ? {1'b0, srtt_reg} : dup_m;

        rtt_gt_slow         = srtt_valid_reg && (!slow_valid_reg || (srtt_reg > slow_reg));
        slow_sample         = !udp_link_reg && item_reg.sample_valid
                              && (item_reg.sample_ms > SLOW_SAMPLE_MS);
        after_plus1         = {1'b0, item_reg.count_after} + 11'd1;
        shrink_cond         = ((after_plus1 < {1'b0, item_reg.count_before}) || slow_sample)
                              && rtt_gt_slow;

        before_c = ({7'd0, item_reg.count_before} > MAX_TASKS) ? MAX_TASKS[9:0]
                                                               : item_reg.count_before;
        after_c  = ({7'd0, item_reg.count_after} > MAX_TASKS) ? MAX_TASKS[9:0]
                                                              : item_reg.count_after;
        d        = before_c - after_c;
        d96      = {1'b0, d, 6'd0} + {2'b00, d, 5'd0};

        w_signed = {1'b0, window_reg} - {1'b0, dec_reg};
        w_neg    = w_signed[17];
        if (server_mode_reg)
        begin
            window_shrink_next = (w_neg || (w_signed[16:0] < MIN_SRV_CAP_Q8)) ? MIN_SRV_CAP_Q8
                                                                              : w_signed[16:0];
        end
        else if (w_neg || (w_signed[16:0] <= HALF_MIN_CAP))
        begin
            window_shrink_next = item_reg.coin ? MIN_CAP_Q8 : HALF_MIN_CAP;
        end
        else
        begin
            window_shrink_next = w_signed[16:0];
        end

        cap          = server_mode_reg ? MAX_CAP_Q8 : HALF_MAX_CAP;
        prod_x32     = {prod_reg, 5'd0};
        prod_x8      = {prod_reg, 3'd0};
        w125         = {window_reg, 7'd0} - {6'd0, window_reg, 1'b0} - {7'd0, window_reg};
        wg125        = {wgrow_reg, 7'd0} - {6'd0, wgrow_reg, 1'b0} - {7'd0, wgrow_reg};
        slow_x5      = {1'b0, slow_reg, 2'b00} + {3'b000, slow_reg};
        grow_cond    = ({13'd0, w125} < prod_x32) && ({3'b000, srtt_reg} < {2'b00, slow_x5[18:2]});
        grow_by_step = (window_reg < thresh_reg) || (window_reg == '0);
        floor_cond   = ({10'd0, wg125} < prod_x8);

        three_r       = {1'b0, srtt_reg, 1'b0} + {2'b00, srtt_reg};
        v4            = {var_reg, 2'b00};
        vterm         = (v4 > RTO_VAR_FLOOR[17:0]) ? v4 : RTO_VAR_FLOOR[17:0];
        rto_base_next = {2'b00, three_r[17:1]} + {1'b0, vterm};

        rto1 = {1'b0, rto_base_reg};
        if (rto1 > RTO_SOFT_CAP)
        begin
            if ({4'd0, srtt_reg} < RTO_FAST_RTT)
            begin
                rto1 = RTO_SOFT_CAP;
            end
            else if (rto1 > RTO_HARD_CAP)
            begin
                rto1 = RTO_HARD_CAP;
            end
        end
        rto2 = rto1;
        if (item_reg.dupe_rate_active)
        begin
            rto2 = rto1 + ((srtt_reg > var_reg) ? {4'd0, srtt_reg} : {4'd0, var_reg});
        end
        lo   = udp_link_reg ? ((srtt_reg > UDP_RTT_KNEE) ? RTO_UDP_HIGH : RTO_UDP_LOW)
                            : RTO_TCP_LOW;
        rto3 = (rto2 < lo) ? lo : rto2;
        rto4 = (rto3 > RTO_HARD_CAP) ? RTO_HARD_CAP : rto3;
        if (srtt_valid_reg)
        begin
            timeout_next = rto4[12:0];
        end
        else
        begin
            timeout_next = server_mode_reg ? RTO_SERVER_DEF : RTO_CLIENT_DEF;
        end

        out_free = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        mul_start     = (state_reg == ST_DECIDE) && !shrink_cond
                        && srtt_valid_reg && slow_valid_reg;
        div_req.start = 1'b0;
        div_req.steps = DIV_CNT_W'(DIV_NUM_W);
        div_dividend  = prod_x8;
        div_divisor   = FLOOR_DIVISOR;
        case (state_reg)
            ST_SHRINK_DEC:
            begin
                div_req.start = (after_c < before_c) && !rtt_gt_slow;
                div_req.steps = DIV_CNT_W'(17);
                div_dividend  = {d96, 18'd0};
                div_divisor   = SHRINK_DIVISOR;
            end
            ST_GROW_CHECK:
            begin
                div_req.start = grow_cond && !grow_by_step;
                div_req.steps = DIV_CNT_W'(17);
                div_dividend  = {17'd65536, 18'd0};
                div_divisor   = window_reg;
            end
            ST_GROW_FLOOR:
            begin
                div_req.start = floor_cond;
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    rrwc_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (item_reg.recv_per_sec),
        .b       (srtt_reg),
        .done    (mul_done),
        .product (mul_product)
    );

    rrwc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            item_reg        <= '0;
            out_data_reg    <= '0;
            out_valid_reg   <= 1'b0;
            server_mode_reg <= 1'b0;
            udp_link_reg    <= 1'b0;
            srtt_valid_reg  <= 1'b0;
            srtt_reg        <= '0;
            var_reg         <= '0;
            slow_valid_reg  <= 1'b0;
            slow_reg        <= '0;
            window_reg      <= WINDOW_RESET;
            thresh_reg      <= THRESH_RESET;
            dec_reg         <= '0;
            prod_reg        <= '0;
            wgrow_reg       <= '0;
            rto_base_reg    <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_SERVER_MODE: server_mode_reg <= cfg_data;
                    CFG_UDP_LINK:    udp_link_reg    <= cfg_data;
                    default:         server_mode_reg <= server_mode_reg;
                endcase
            end

            if (out_valid_reg && out_ready && (state_reg != ST_TO_FINAL))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        item_reg  <= in_data;
                        state_reg <= ST_RTT_UPD;
                    end
                end
                ST_RTT_UPD:
                begin
                    if (item_reg.req_type)
                    begin
                        state_reg <= ST_SHRINK_DEC;
                    end
                    else
                    begin
                        if (item_reg.sample_valid)
                        begin
                            srtt_valid_reg <= 1'b1;
                            if (!srtt_valid_reg)
                            begin
                                srtt_reg <= item_reg.sample_ms;
                                var_reg  <= srtt_first_var_next;
                            end
                            else
                            begin
                                srtt_reg <= srtt_upd_next;
                                var_reg  <= var_upd_next;
                            end
                        end
                        state_reg <= ST_SLOW_UPD;
                    end
                end
                ST_SLOW_UPD:
                begin
                    if (item_reg.sample_valid)
                    begin
                        slow_valid_reg <= 1'b1;
                        slow_reg       <= slow_valid_reg ? slow_sum[18:3] : srtt_reg;
                    end
                    state_reg <= ST_DUP_UPD;
                end
                ST_DUP_UPD:
                begin
                    if (item_reg.duplicate && srtt_valid_reg && (srtt_reg != '0)
                        && (dup_m_cap > {1'b0, var_reg}))
                    begin
                        var_reg <= dup_m_cap[15:0];
                    end
                    state_reg <= ST_DECIDE;
                end
                ST_DECIDE:
                begin
                    if (shrink_cond)
                    begin
                        state_reg <= ST_SHRINK_DEC;
                    end
                    else if (srtt_valid_reg && slow_valid_reg)
                    begin
                        state_reg <= ST_MUL_WAIT;
                    end
                    else
                    begin
                        state_reg <= ST_TO_BASE;
                    end
                end
                ST_SHRINK_DEC:
                begin
                    if (after_c >= before_c)
                    begin
                        state_reg <= ST_TO_BASE;
                    end
                    else if (rtt_gt_slow)
                    begin
                        dec_reg   <= {2'b00, d, 5'd0};
                        state_reg <= ST_SHRINK_APPLY;
                    end
                    else
                    begin
                        state_reg <= ST_SHRINK_DIV;
                    end
                end
                ST_SHRINK_DIV:
                begin
                    if (div_done)
                    begin
                        dec_reg   <= div_quotient[16:0];
                        state_reg <= ST_SHRINK_APPLY;
                    end
                end
                ST_SHRINK_APPLY:
                begin
                    if (w_neg || (w_signed[16:0] < MIN_CAP_Q8))
                    begin
                        thresh_reg <= w_neg ? '0 : w_signed[16:0];
                    end
                    window_reg <= window_shrink_next;
                    state_reg  <= ST_TO_BASE;
                end
                ST_MUL_WAIT:
                begin
                    if (mul_done)
                    begin
                        prod_reg  <= mul_product;
                        state_reg <= ST_GROW_CHECK;
                    end
                end
                ST_GROW_CHECK:
                begin
                    if (!grow_cond)
                    begin
                        state_reg <= ST_TO_BASE;
                    end
                    else if (grow_by_step)
                    begin
                        wgrow_reg <= {1'b0, window_reg} + {1'b0, GROW_STEP_Q8};
                        state_reg <= ST_GROW_FLOOR;
                    end
                    else
                    begin
                        state_reg <= ST_GROW_DIV;
                    end
                end
                ST_GROW_DIV:
                begin
                    if (div_done)
                    begin
                        wgrow_reg <= {1'b0, window_reg} + div_quotient[17:0];
                        state_reg <= ST_GROW_FLOOR;
                    end
                end
                ST_GROW_FLOOR:
                begin
                    state_reg <= floor_cond ? ST_FLOOR_DIV : ST_GROW_CAP;
                end
                ST_FLOOR_DIV:
                begin
                    if (div_done)
                    begin
                        wgrow_reg <= ({18'd0, cap} < div_quotient) ? {1'b0, cap}
                                                                   : div_quotient[17:0];
                        state_reg <= ST_GROW_CAP;
                    end
                end
                ST_GROW_CAP:
                begin
                    window_reg <= (wgrow_reg > {1'b0, cap}) ? cap : wgrow_reg[16:0];
                    state_reg  <= ST_TO_BASE;
                end
                ST_TO_BASE:
                begin
                    rto_base_reg <= rto_base_next;
                    state_reg    <= ST_TO_FINAL;
                end
                ST_TO_FINAL:
                begin
                    if (out_free)
                    begin
                        out_data_reg.timeout_ms <= timeout_next;
                        out_data_reg.window_q8  <= window_reg;
                        out_valid_reg           <= 1'b1;
                        state_reg               <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while a request is still being processed");

    a_window_cap: assert property (@(posedge clk) disable iff (!rst_n)
        window_reg <= MAX_CAP_Q8)
        else $error("window above its absolute cap");

    a_slow_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) && srtt_valid_reg |-> slow_valid_reg)
        else $error("smoothed RTT valid without a slow RTT average");

    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_SHRINK_DIV) || (state_reg == ST_GROW_DIV)
                     || (state_reg == ST_FLOOR_DIV))
        else $error("divider finished outside a divide wait state");

    a_timeout_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_data_reg.timeout_ms <= RTO_HARD_CAP[12:0])
        else $error("timeout above its cap");

endmodule

`default_nettype wire

@@ rtl/rrwc_mul.sv @@
`default_nettype none

module rrwc_mul (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [rrwc_pkg::MUL_W-1:0]    a,
    input  wire logic [rrwc_pkg::MUL_W-1:0]    b,
    output logic                               done,
    output logic [2*rrwc_pkg::MUL_W-1:0]       product
);
    import rrwc_pkg::*;

    logic                   busy_reg;
    logic                   done_reg;
    logic [MUL_CNT_W-1:0]   cnt_reg;
    logic [2*MUL_W-1:0]     mcand_reg;
    logic [MUL_W-1:0]       mplier_reg;
    logic [2*MUL_W-1:0]     acc_reg;
    logic [2*MUL_W-1:0]     acc_next;

    always_comb
    begin
        acc_next = acc_reg;
        if (mplier_reg[0])
        begin
            acc_next = acc_reg + mcand_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (cnt_reg == MUL_CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= MUL_CNT_W'(MUL_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == MUL_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg  <= {{MUL_W{1'b0}}, a};
            mplier_reg <= b;
            acc_reg    <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg    <= acc_next;
            mcand_reg  <= {mcand_reg[2*MUL_W-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[MUL_W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

`default_nettype wire

@@ rtl/rrwc_div.sv @@
`default_nettype none

module rrwc_div (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire rrwc_pkg::div_req_t                req,
    input  wire logic [rrwc_pkg::DIV_NUM_W-1:0]    dividend,
    input  wire logic [rrwc_pkg::DIV_DEN_W-1:0]    divisor,
    output logic                                   done,
    output logic [rrwc_pkg::DIV_NUM_W-1:0]         quotient
);
    import rrwc_pkg::*;

    logic                   busy_reg;
    logic                   done_reg;
    logic [DIV_CNT_W-1:0]   cnt_reg;
    logic [DIV_DEN_W-1:0]   rem_reg;
    logic [DIV_DEN_W-1:0]   den_reg;
    logic [DIV_NUM_W-1:0]   quo_reg;
    logic [DIV_DEN_W:0]     trial;
    logic [DIV_DEN_W:0]     trial_diff;
    logic                   fits;
    logic [DIV_DEN_W-1:0]   rem_next;

    // The dividend arrives aligned so that its top bit is the first one shifted in.
    always_comb
    begin
        trial      = {rem_reg, quo_reg[DIV_NUM_W-1]};
        trial_diff = trial - {1'b0, den_reg};
        fits       = (trial >= {1'b0, den_reg});
        rem_next   = fits ? trial_diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= !req.start && busy_reg && (cnt_reg == DIV_CNT_W'(1));
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_NUM_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

@@ test/tb_rtt_rto_window_controller.sv @@
`timescale 1ns / 1ps

module tb_rtt_rto_window_controller;

    import rrwc_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned RANDOM_ITEMS = 180;
    localparam int unsigned HOLD_CYCLES  = 400;

    typedef struct {
        logic server;
        logic udp;
        in_t  item;
        logic typed;
        out_t want;
    } vec_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_t  in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_index = 1'b0;
    logic cfg_data = 1'b0;

    logic        server_cfg = 1'b0;
    logic        udp_cfg = 1'b0;
    logic        have_rtt = 1'b0;
    logic [15:0] srtt = '0;
    logic [15:0] rttvar = '0;
    logic        have_slow = 1'b0;
    logic [15:0] slow_avg = '0;
    logic [16:0] win = 17'd5120;
    logic [16:0] ssthresh = 17'd32768;

    out_t        expected_q[$];
    vec_row_t    dir_rows[$];
    int unsigned mismatch_count = 0;
    int unsigned results_seen = 0;
    int unsigned requests_sent = 0;
    int unsigned settings_count = 0;
    int unsigned shrink_count = 0;
    int unsigned growth_count = 0;
    int unsigned cycle_count = 0;
    logic        gaps_on = 1'b1;
    logic        rx_hold = 1'b0;
    event        stall_kick;

    rtt_rto_window_controller i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic longint rtt_or_none();
        return have_rtt ? longint'(srtt) : -1;
    endfunction

    function automatic longint slow_or_none();
        return have_slow ? longint'(slow_avg) : -1;
    endfunction

    task automatic shrink_window(input logic [9:0] cnt_before, input logic [9:0] cnt_after,
                                 input logic coin);
        longint d;
        longint dec;
        longint w;
        if (cnt_after >= cnt_before)
            return;
        shrink_count++;
        d = longint'(cnt_before) - longint'(cnt_after);
        dec = (slow_or_none() < rtt_or_none()) ? d * 32 : (d * 96) / 5;
        w = longint'(win) - dec;
        if (w < 5120)
            ssthresh = (w < 0) ? 17'd0 : w[16:0];
        if (server_cfg)
        begin
            if (w < 25600)
                w = 25600;
        end
        else if (w <= 2560)
        begin
            w = coin ? 5120 : 2560;
        end
        win = w[16:0];
    endtask

    function automatic longint rto_now(input logic dupe_rate);
        longint r;
        longint v;
        longint rto;
        longint lo;
        if (!have_rtt)
            return server_cfg ? 1500 : 2500;
        r = srtt;
        v = rttvar;
        rto = (3 * r) / 2 + ((4 * v > 250) ? 4 * v : 250);
        if (rto > 5000)
        begin
            if (r < 2500)
                rto = 5000;
            else if (rto > 6000)
                rto = 6000;
        end
        if (dupe_rate)
            rto += (r > v) ? r : v;
        lo = udp_cfg ? ((r > 150) ? 1500 : 500) : 4000;
        if (rto < lo)
            rto = lo;
        if (rto > 6000)
            rto = 6000;
        return rto;
    endfunction

    task automatic advance_estimator(input in_t req, output out_t res);
        longint t;
        longint s;
        longint diff;
        longint m;
        longint prod;
        longint w;
        longint cap;
        logic   slow_sample;
        t = req.sample_ms;
        if (req.req_type)
        begin
            shrink_window(req.count_before, req.count_after, req.coin);
        end
        else
        begin
            if (req.sample_valid)
            begin
                if (!have_rtt)
                begin
                    srtt = req.sample_ms;
                    rttvar = 16'((t / 2 > 100) ? t / 2 : 100);
                    have_rtt = 1'b1;
                end
                else
                begin
                    s = srtt;
                    diff = (s > t) ? s - t : t - s;
                    rttvar = 16'((3 * longint'(rttvar) + diff) / 4);
                    srtt = 16'((7 * s + t) / 8);
                end
                if (!have_slow)
                begin
                    slow_avg = srtt;
                    have_slow = 1'b1;
                end
                else
                begin
                    slow_avg = 16'((7 * longint'(slow_avg) + longint'(srtt)) / 8);
                end
            end
            if (req.duplicate && have_rtt && srtt > 0)
            begin
                s = srtt;
                m = longint'(rttvar) + s / 4;
                if (m > s)
                    m = s;
                if (m > longint'(rttvar))
                    rttvar = 16'(m);
            end
            slow_sample = !udp_cfg && req.sample_valid && (req.sample_ms > 2500);
            if (((longint'(req.count_after) + 1 < longint'(req.count_before)) || slow_sample)
                && rtt_or_none() > slow_or_none())
            begin
                shrink_window(req.count_before, req.count_after, req.coin);
            end
            else if (have_rtt && have_slow)
            begin
                prod = longint'(req.recv_per_sec) * longint'(srtt);
                w = win;
                if (prod * 256 > w * 1000 && longint'(srtt) < (longint'(slow_avg) * 5) / 4)
                begin
                    cap = server_cfg ? 76800 : 38400;
                    if (w < longint'(ssthresh) || w == 0)
                        w += 256;
                    else
                        w += 65536 / w;
                    if (w * 4000 < prod * 256)
                        w = (prod * 64) / 1000;
                    if (w > cap)
                        w = cap;
                    win = w[16:0];
                    growth_count++;
                end
            end
        end
        res.timeout_ms = 13'(rto_now(req.dupe_rate_active));
        res.window_q8 = win;
    endtask

    function automatic in_t mk_req(input logic req_type, input logic sample_valid,
                                   input logic [15:0] sample_ms, input logic duplicate,
                                   input logic dupe_rate, input logic [9:0] cnt_before,
                                   input logic [9:0] cnt_after, input logic [15:0] recv,
                                   input logic coin);
        in_t r;
        r.req_type = req_type;
        r.sample_valid = sample_valid;
        r.sample_ms = sample_ms;
        r.duplicate = duplicate;
        r.dupe_rate_active = dupe_rate;
        r.count_before = cnt_before;
        r.count_after = cnt_after;
        r.recv_per_sec = recv;
        r.coin = coin;
        return r;
    endfunction

    function automatic vec_row_t row(input logic server, input logic udp, input in_t item,
                                     input logic typed, input int tmo, input int wnd);
        vec_row_t v;
        v.server = server;
        v.udp = udp;
        v.item = item;
        v.typed = typed;
        v.want.timeout_ms = 13'(tmo);
        v.want.window_q8 = 17'(wnd);
        return v;
    endfunction

    task automatic queue_row(input vec_row_t r);
        dir_rows.insert(dir_rows.size(), r);
    endtask

    function automatic in_t random_request();
        in_t         r;
        int unsigned pick;
        r.req_type = ($urandom_range(99) < 25);
        r.sample_valid = ($urandom_range(99) < 85);
        pick = $urandom_range(99);
        if (pick < 55)
            r.sample_ms = 16'($urandom_range(400));
        else if (pick < 80)
            r.sample_ms = 16'($urandom_range(3000));
        else if (pick < 90)
            r.sample_ms = 16'($urandom_range(2400, 2600));
        else
            r.sample_ms = 16'($urandom());
        r.duplicate = ($urandom_range(99) < 20);
        r.dupe_rate_active = ($urandom_range(99) < 20);
        r.count_after = 10'($urandom());
        pick = $urandom_range(99);
        if (pick < 50)
            r.count_before = r.count_after;
        else if (pick < 75)
            r.count_before = r.count_after + 10'($urandom_range(3));
        else
            r.count_before = 10'($urandom());
        if ($urandom_range(1) == 0)
            r.recv_per_sec = 16'($urandom_range(2000));
        else
            r.recv_per_sec = 16'($urandom());
        r.coin = 1'($urandom_range(1));
        return r;
    endfunction

    task automatic send_item(input in_t item, input logic typed, input out_t want);
        out_t res;
        while (gaps_on && $urandom_range(99) < 7)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        advance_estimator(item, res);
        expected_q.insert(expected_q.size(), typed ? want : res);
        requests_sent++;
    endtask

    task automatic settle_and_configure(input logic server, input logic udp);
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_SERVER_MODE;
        cfg_data <= server;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        server_cfg = server;
        cfg_index <= CFG_UDP_LINK;
        cfg_data <= udp;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        udp_cfg = udp;
        cfg_valid <= 1'b0;
        settings_count++;
    endtask

    always @(posedge clk)
    begin
        out_ready <= rx_hold ? 1'b0 : (!gaps_on || $urandom_range(99) >= 7);
    end

    initial
    begin
        int unsigned hold_n;
        forever
        begin
            @(stall_kick);
            rx_hold = 1'b1;
            for (hold_n = 0; hold_n < HOLD_CYCLES; hold_n++)
                @(posedge clk);
            rx_hold = 1'b0;
        end
    end

    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result, actual timeout_ms %0d window_q8 %0d",
                         $time, out_data.timeout_ms, out_data.window_q8);
                mismatch_count++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (out_data.timeout_ms !== want.timeout_ms)
                begin
                    $display("%0t: timeout_ms mismatch, expected %0d, actual %0d",
                             $time, want.timeout_ms, out_data.timeout_ms);
                    mismatch_count++;
                end
                if (out_data.window_q8 !== want.window_q8)
                begin
                    $display("%0t: window_q8 mismatch, expected %0d, actual %0d",
                             $time, want.window_q8, out_data.window_q8);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, expected_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        int unsigned ph;
        int unsigned k;
        logic        server;
        logic        udp;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows are driven first; the first four check typed expected results.
        queue_row(row(0, 0, mk_req(1, 0, 0, 0, 0, 0, 0, 0, 0), 1, 2500, 5120));
        queue_row(row(1, 0, mk_req(1, 0, 0, 0, 0, 5, 9, 0, 0), 1, 1500, 5120));
        queue_row(row(1, 1, mk_req(0, 0, 16'hFFFF, 1, 1, 1023, 0, 16'hFFFF, 1),
                      1, 1500, 5120));
        queue_row(row(0, 0, mk_req(0, 1, 0, 1, 1, 0, 0, 16'hFFFF, 0), 1, 4000, 5120));
        for (k = 0; k < 3; k++)
            queue_row(row(0, 0, mk_req(0, 1, 2000, 0, 0, 0, 0, 300, 0), 0, 0, 0));
        for (k = 0; k < 3; k++)
            queue_row(row(0, 0, mk_req(0, 1, 0, 0, 0, 0, 0, 300, 1), 0, 0, 0));
        queue_row(row(0, 0, mk_req(0, 1, 0, 0, 0, 0, 0, 16'hFFFF, 0), 0, 0, 0));
        queue_row(row(0, 0, mk_req(1, 0, 0, 0, 0, 1023, 0, 0, 1), 0, 0, 0));
        queue_row(row(0, 0, mk_req(1, 0, 0, 0, 0, 1023, 0, 0, 0), 0, 0, 0));
        queue_row(row(1, 0, mk_req(1, 0, 0, 0, 0, 1023, 0, 0, 0), 0, 0, 0));
        queue_row(row(0, 0, mk_req(0, 1, 16'hFFFF, 1, 1, 1023, 0, 16'hFFFF, 1),
                      0, 0, 0));
        queue_row(row(0, 0, mk_req(0, 1, 2501, 0, 0, 0, 0, 100, 0), 0, 0, 0));
        queue_row(row(0, 1, mk_req(0, 1, 16'hFFFF, 0, 0, 2, 0, 0, 0), 0, 0, 0));
        queue_row(row(0, 1, mk_req(0, 1, 100, 1, 1, 0, 0, 1000, 1), 0, 0, 0));
        queue_row(row(1, 1, mk_req(1, 0, 0, 0, 0, 1, 0, 0, 1), 0, 0, 0));
        queue_row(row(1, 1, mk_req(0, 1, 16'hFFFF, 1, 1, 0, 1023, 16'hFFFF, 1),
                      0, 0, 0));
        queue_row(row(0, 0, mk_req(0, 0, 0, 1, 1, 3, 1, 0, 0), 0, 0, 0));
        queue_row(row(0, 0, mk_req(1, 1, 16'hFFFF, 1, 1, 0, 1023, 16'hFFFF, 1),
                      0, 0, 0));

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].server !== server_cfg || dir_rows[i].udp !== udp_cfg)
                settle_and_configure(dir_rows[i].server, dir_rows[i].udp);
            send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
        end

        for (ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin server = 1'b1; udp = 1'b0; end
                1: begin server = 1'b0; udp = 1'b1; end
                2: begin server = 1'b1; udp = 1'b1; end
                3: begin server = 1'b0; udp = 1'b0; end
                default:
                begin
                    server = 1'($urandom_range(1));
                    udp = 1'($urandom_range(1));
                end
            endcase
            settle_and_configure(server, udp);
            gaps_on = (ph != 3);
            for (k = 0; k < RANDOM_ITEMS; k++)
            begin
                if (ph == 1 && k == 40)
                    -> stall_kick;
                send_item(random_request(), 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("Sent %0d requests (%0d directed) and checked %0d results over %0d settings.",
                 requests_sent, dir_rows.size(), results_seen, settings_count);
        $display("The predicted window shrank %0d times and grew %0d times.",
                 shrink_count, growth_count);
        if (mismatch_count == 0 && expected_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
